[hw/rtl/dcbi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcbi_pkg: shared types and constants
// Types, codes and widths used by the buffer index block.
// ----------------------------------------------------------------------------
package dcbi_pkg;

    localparam int MAX_WRITERS = 16;
    localparam int WID_W       = 4;
    localparam int CNT_W       = 5;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_WRITER_COUNT = 2'd0,
        REG_BUFFER_SIZE  = 2'd1,
        REG_READER_PER   = 2'd2,
        REG_HYPERPERIOD  = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OWN_RD,
        ST_OWN_WAIT,
        ST_TIME,
        ST_ENT_RD,
        ST_ENT_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_ACC,
        ST_MOD_GO,
        ST_MOD_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  writer_id;
        logic [15:0] iteration;
        logic [15:0] entry_period;
        logic [15:0] entry_deadline;
    } in_item_t;

    typedef struct packed {
        logic [15:0] slot_index;
        logic [15:0] next_slot;
        logic        bad_writer;
        logic        negative_time;
    } out_item_t;

endpackage

[hw/rtl/dcbi_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcbi_ram: generic single-port RAM
// One write or read port, read data registered.
// ----------------------------------------------------------------------------
module dcbi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[hw/rtl/dcbi_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcbi_div: restoring divider
// Unsigned 50 by 32 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dcbi_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [49:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [49:0] quotient,
    output logic [31:0] remainder
);

    logic [49:0] q_reg;
    logic [31:0] d_reg;
    logic [32:0] r_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;

    assign trial     = {r_reg[31:0], q_reg[49]};
    assign quotient  = q_reg;
    assign remainder = r_reg[31:0];
    assign done      = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd50;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            q_reg <= dividend;
            d_reg <= divisor;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_reg <= trial - {1'b0, d_reg};
                q_reg <= {q_reg[48:0], 1'b1};
            end
            else
            begin
                r_reg <= trial;
                q_reg <= {q_reg[48:0], 1'b0};
            end
        end
    end

endmodule

[hw/rtl/delayed_comm_buffer_index.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delayed_comm_buffer_index: shared buffer slot calculator
// Computes write and read slots of a delayed-communication message buffer.
// ----------------------------------------------------------------------------
// Usage. A command beat is taken at a clock edge where start is high and busy
// is low. Loads write one writer's period and deadline into the entry RAM.
// Write queries give the slot a writer's job fills; read queries give the
// current and next reader slots. Exactly one result beat follows each command,
// flagged by done for a single cycle; the receiver cannot stall it.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user
// does so only while idle, as the block itself does not enforce this.
// A load, an unknown operation or a write query with a bad writer id goes
// straight from idle to the result state. A query reads each writer entry
// from the registered-read RAM and runs one 50-step restoring division per
// writer, then one more division for the modulo reduction, all on the shared
// serial divider. One command is in flight at a time.
// Reset returns the registers to a writer count of 1, a buffer size of 1, a
// reader period of 1 and a hyperperiod of 0, and leaves the entry RAM
// contents undefined.
// ----------------------------------------------------------------------------
module delayed_comm_buffer_index (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  dcbi_pkg::in_item_t  cmd,
    output logic                done,
    output dcbi_pkg::out_item_t result,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    import dcbi_pkg::*;

    // Configuration registers.
    logic [4:0]  wcount_reg;
    logic [15:0] bsize_reg;
    logic [15:0] rper_reg;
    logic [31:0] hyper_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcount_reg <= 5'd1;
            bsize_reg  <= 16'd1;
            rper_reg   <= 16'd1;
            hyper_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_WRITER_COUNT: wcount_reg <= cfg_data[4:0];
                REG_BUFFER_SIZE:  bsize_reg  <= cfg_data[15:0];
                REG_READER_PER:   rper_reg   <= cfg_data[15:0];
                REG_HYPERPERIOD:  hyper_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Writers in use, limited to the table depth.
    logic [CNT_W-1:0] n_use;
    assign n_use = (wcount_reg > CNT_W'(MAX_WRITERS)) ? CNT_W'(MAX_WRITERS) : wcount_reg;

    state_t state_reg, state_next;

    in_item_t          item_reg;
    logic [WID_W-1:0]  j_reg, j_next;
    logic signed [49:0] t_reg, t_next;     // query time, signed
    logic signed [49:0] sum_reg, sum_next;
    logic [15:0]       own_per_reg, own_per_next;
    logic [15:0]       own_dl_reg, own_dl_next;
    logic [15:0]       per_reg, per_next;
    logic signed [49:0] gap_reg, gap_next;
    logic              neg_reg, neg_next;
    logic              bad_reg, bad_next;
    out_item_t         res_reg, res_next;
    logic              done_reg, done_next;
    logic              accept;

    // Marks that the modulo division has been launched.
    logic u_div_started_reg;

    // Entry RAM: {period, deadline}.
    logic              ram_we;
    logic [WID_W-1:0]  ram_addr;
    logic [31:0]       ram_wdata, ram_rdata;

    dcbi_ram #(.WIDTH(32), .DEPTH(MAX_WRITERS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Shared divider.
    logic        div_go, div_done;
    logic [49:0] div_a, div_q;
    logic [31:0] div_b, div_r;

    dcbi_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (div_go),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= cmd;
        end
        j_reg       <= j_next;
        t_reg       <= t_next;
        sum_reg     <= sum_next;
        own_per_reg <= own_per_next;
        own_dl_reg  <= own_dl_next;
        per_reg     <= per_next;
        gap_reg     <= gap_next;
        neg_reg     <= neg_next;
        bad_reg     <= bad_next;
        res_reg     <= res_next;
    end

    logic [15:0]       per_eff, own_eff;
    logic [49:0]       gap_mag;
    logic              exact;
    logic signed [49:0] q_signed;
    logic [15:0]       bs_eff;
    logic [31:0]       slot_w, slot_inc;

    assign per_eff  = (ram_rdata[31:16] == 16'd0) ? 16'd1 : ram_rdata[31:16];
    assign own_eff  = (own_per_reg == 16'd0) ? 16'd1 : own_per_reg;
    assign gap_mag  = gap_reg[49] ? 50'(-gap_reg) : 50'(gap_reg);
    assign exact    = (div_r == 32'd0);
    assign q_signed = gap_reg[49] ? -$signed(div_q) : $signed(div_q);
    assign bs_eff   = (bsize_reg == 16'd0) ? 16'd1 : bsize_reg;
    assign slot_w   = {16'd0, div_r[15:0]};

    always_comb
    begin
        state_next   = state_reg;
        j_next       = j_reg;
        t_next       = t_reg;
        sum_next     = sum_reg;
        own_per_next = own_per_reg;
        own_dl_next  = own_dl_reg;
        per_next     = per_reg;
        gap_next     = gap_reg;
        neg_next     = neg_reg;
        bad_next     = bad_reg;
        res_next     = res_reg;
        done_next    = 1'b0;
        ram_we       = 1'b0;
        ram_addr     = j_reg;
        ram_wdata    = {item_reg.entry_period, item_reg.entry_deadline};
        div_go       = 1'b0;
        div_a        = gap_mag;
        div_b        = {16'd0, per_reg};
        slot_inc     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    j_next   = '0;
                    sum_next = '0;
                    neg_next = 1'b0;
                    bad_next = 1'b0;
                    case (op_t'(cmd.operation))
                        OP_LOAD:  state_next = ST_DONE;
                        OP_WRITE:
                        begin
                            if ({1'b0, cmd.writer_id} >= n_use)
                            begin
                                bad_next   = 1'b1;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_OWN_RD;
                            end
                        end
                        OP_READ:
                        begin
                            // With no writers in use the sum is zero.
                            if (n_use == '0)
                            begin
                                state_next = ST_MOD_GO;
                            end
                            else
                            begin
                                state_next = ST_TIME;
                            end
                        end
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_OWN_RD:
            begin
                ram_addr   = item_reg.writer_id;
                state_next = ST_OWN_WAIT;
            end
            ST_OWN_WAIT:
            begin
                own_per_next = ram_rdata[31:16];
                own_dl_next  = ram_rdata[15:0];
                state_next   = ST_TIME;
            end
            ST_TIME:
            begin
                if (op_t'(item_reg.operation) == OP_WRITE)
                begin
                    t_next = $signed(50'({16'd0, item_reg.iteration} * {16'd0, own_eff}))
                           + $signed(50'(own_dl_reg));
                end
                else
                begin
                    t_next = $signed(50'(hyper_reg))
                           + $signed(50'({16'd0, item_reg.iteration} * {16'd0, rper_reg}));
                end
                state_next = ST_ENT_RD;
            end
            ST_ENT_RD:
            begin
                state_next = ST_ENT_WAIT;
            end
            ST_ENT_WAIT:
            begin
                per_next   = per_eff;
                gap_next   = t_reg - $signed(50'(ram_rdata[15:0]));
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                div_go     = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (op_t'(item_reg.operation) == OP_WRITE)
                begin
                    if (!gap_reg[49])
                    begin
                        sum_next = sum_reg + $signed(div_q) + 50'sd1;
                    end
                    else
                    begin
                        neg_next = 1'b1;
                    end
                    if (j_reg >= item_reg.writer_id && exact)
                    begin
                        sum_next = sum_next - 50'sd1;
                    end
                end
                else
                begin
                    if (gap_reg[49])
                    begin
                        neg_next = 1'b1;
                    end
                    sum_next = sum_reg + q_signed + 50'sd1;
                end
                if ({1'b0, j_reg} + 5'd1 >= n_use)
                begin
                    state_next = ST_MOD_GO;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_ENT_RD;
                end
            end
            ST_MOD_GO:
            begin
                gap_next   = sum_reg;
                per_next   = bs_eff;
                state_next = ST_MOD_WAIT;
            end
            ST_MOD_WAIT:
            begin
                // The divider runs on the magnitude; a negative sum is folded after.
                if (div_done)
                begin
                    if (gap_reg[49] && div_r != 32'd0)
                    begin
                        slot_inc = {16'd0, per_reg} - div_r;
                    end
                    else
                    begin
                        slot_inc = slot_w;
                    end
                    res_next.slot_index = slot_inc[15:0];
                    if (slot_inc[15:0] + 16'd1 >= per_reg)
                    begin
                        res_next.next_slot = '0;
                    end
                    else
                    begin
                        res_next.next_slot = slot_inc[15:0] + 16'd1;
                    end
                    if (op_t'(item_reg.operation) != OP_READ)
                    begin
                        res_next.next_slot = '0;
                    end
                    res_next.bad_writer    = 1'b0;
                    res_next.negative_time = neg_reg;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!u_div_started_reg)
                begin
                    div_go = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (op_t'(item_reg.operation) == OP_LOAD)
                begin
                    ram_addr = item_reg.writer_id;
                    ram_we   = 1'b1;
                end
                res_next.slot_index    = '0;
                res_next.next_slot     = '0;
                res_next.bad_writer    = bad_reg;
                res_next.negative_time = 1'b0;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_div_started_reg <= 1'b0;
        end
        else if (state_reg == ST_MOD_WAIT)
        begin
            u_div_started_reg <= 1'b1;
        end
        else
        begin
            u_div_started_reg <= 1'b0;
        end
    end

    // Assertions.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a command in flight");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.slot_index < bs_eff))
        else $error("slot outside buffer");

endmodule
